>>> hw/rtl/rvex_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_pkg
// Shared types, opcodes and status codes of the RV64IM execute core.
// ----------------------------------------------------------------------------
package rvex_pkg;

  typedef struct packed {
    logic        command;
    logic [31:0] instruction;
    logic [63:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] instr_pc;
    logic [63:0] next_pc;
    logic        mem_read;
    logic        mem_write;
    logic [63:0] mem_addr;
    logic [3:0]  mem_bytes;
    logic [63:0] store_data;
    logic [63:0] halt_code;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic md_start;
    logic md_take;
    logic commit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_md;
    logic md_done;
    logic out_free;
  } dp_stat_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_SYSTEM  = 3'd3;
  localparam logic [2:0] ST_PROTO   = 3'd4;

  localparam logic       CMD_EXEC  = 1'b0;
  localparam logic       CMD_LOAD  = 1'b1;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_IMM32  = 7'h1b;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_REG32  = 7'h3b;
  localparam logic [6:0] OP_FENCE  = 7'h0f;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [5:0] F6_BASE   = 6'h00;
  localparam logic [5:0] F6_ALT    = 6'h10;

  localparam logic [31:0] INS_EBREAK = 32'h0010_0073;
  localparam logic [31:0] INS_ECALL  = 32'h0000_0073;
  localparam logic [31:0] INS_MRET   = 32'h3020_0073;

  localparam logic [4:0]  REG_A0     = 5'd10;
  localparam logic [63:0] RESET_PC_DEFAULT = 64'h0000_0000_8000_0000;

  function automatic logic [63:0] sext32(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rv64im_execute_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv64im_execute_core
// RV64IM execute core: 32 x 64-bit register file, program counter, M unit.
// ----------------------------------------------------------------------------
// Each request on the input channel carries either an instruction word to
// execute at the current pc or the data that answers an outstanding load.
// Every request produces exactly one result request on the output channel
// with status, pc values and any memory read or write request.
// The controller runs capture, execute and commit in turn, so a base integer
// instruction is registered at execute, written into the output register at
// commit and is visible on the outputs from then on. After commit the
// controller returns to idle and can accept the next request.
// Multiply and divide add a wait state for the one-bit-per-cycle shared
// multiply/divide unit. One request is in work at a time; the input is stalled
// from acceptance until commit.
// The output register holds a finished result while the receiver stalls, and
// the next request may be accepted meanwhile; its commit waits for the slot.
// Reset clears the register file through per-entry valid bits, drops any
// pending load and loads the pc from the reset_pc register, which itself
// returns to 0x80000000 and is rewritten through cfg_write and cfg_data.
// ----------------------------------------------------------------------------
module rv64im_execute_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [63:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rvex_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rvex_pkg::out_item_t      out_item
);
  import rvex_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // The controller owns sequencing only; all data lives in the datapath.
  rvex_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rvex_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // A commit never overwrites a result the receiver has not taken.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("commit into an occupied output register");

  // Every commit presents a result in the next cycle.
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit without output valid");

  // An accepted request is executed in the following cycle.
  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.exec)
    else $error("captured request not executed");

endmodule
`default_nettype wire

>>> hw/rtl/rvex_muldiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_muldiv
// Iterative radix-2 multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module rvex_muldiv (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [2:0]  fn,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      result
);
  import rvex_pkg::*;

  localparam logic [6:0] STEPS = 7'd64;
  localparam logic [6:0] FIX1  = 7'd64;
  localparam logic [6:0] FIX2  = 7'd65;
  localparam logic [6:0] LAST  = 7'd66;

  logic        busy;
  logic [6:0]  cnt;
  logic [63:0] hi, lo, x, y;
  logic [2:0]  fn_q;
  logic        na, nb, zero;
  logic [64:0] msum;
  logic [65:0] diff;
  logic        is_mul, sgn_div;

  assign is_mul  = ~fn[2];
  assign sgn_div = (fn == 3'd4) || (fn == 3'd6);
  assign msum = {1'b0, hi} + (lo[0] ? {1'b0, x} : 65'd0);
  assign diff = {1'b0, hi, lo[63]} - {2'b00, y};
  assign done = busy && (cnt == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 7'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'd0;
    end else if (busy) begin
      if (cnt == LAST) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      fn_q <= fn;
      hi   <= 64'd0;
      zero <= (b == 64'd0);
      if (is_mul) begin
        x  <= a;
        y  <= b;
        lo <= b;
        na <= ((fn == 3'd1) || (fn == 3'd2)) && a[63];
        nb <= (fn == 3'd1) && b[63];
      end else begin
        x  <= a;
        y  <= (sgn_div && b[63]) ? (64'd0 - b) : b;
        lo <= (sgn_div && a[63]) ? (64'd0 - a) : a;
        na <= sgn_div && (a[63] ^ b[63]);
        nb <= sgn_div && a[63];
      end
    end else if (busy) begin
      if (cnt < STEPS) begin
        if (!fn_q[2]) begin
          hi <= msum[64:1];
          lo <= {msum[0], lo[63:1]};
        end else if (!diff[65]) begin
          hi <= diff[63:0];
          lo <= {lo[62:0], 1'b1};
        end else begin
          hi <= {hi[62:0], lo[63]};
          lo <= {lo[62:0], 1'b0};
        end
      end else if (cnt == FIX1) begin
        // Signed corrections: high product terms, or quotient sign.
        if (!fn_q[2]) begin
          hi <= hi - (na ? y : 64'd0);
        end else if (na) begin
          lo <= 64'd0 - lo;
        end
      end else if (cnt == FIX2) begin
        if (!fn_q[2]) begin
          hi <= hi - (nb ? x : 64'd0);
        end else if (nb) begin
          hi <= 64'd0 - hi;
        end
      end
    end
  end

  always_comb begin
    case (fn_q)
      3'd0:          result = lo;
      3'd1, 3'd2, 3'd3: result = hi;
      3'd4, 3'd5:    result = zero ? 64'hffff_ffff_ffff_ffff : lo;
      default:       result = zero ? x : hi;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/rvex_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_datapath
// Register file, decode and ALU, architectural state and output register.
// ----------------------------------------------------------------------------
module rvex_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [63:0]         cfg_data,
  input  wire rvex_pkg::in_item_t  in_item,
  input  wire rvex_pkg::ctl_cmd_t  cmd,
  output rvex_pkg::dp_stat_t       stat,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rvex_pkg::out_item_t      out_item
);
  import rvex_pkg::*;

  logic [63:0] reset_pc, pc;
  logic        load_pending;
  logic [4:0]  load_dest;
  logic [2:0]  load_kind;

  logic [63:0] rf [32];
  logic [31:0] rf_valid;
  logic [63:0] q1, q2;
  logic        v1, v2;
  logic [4:0]  ra1, ra2;

  logic        cur_cmd;
  logic [31:0] ins;
  logic [63:0] ldata;

  out_item_t   r_item, n_item;
  logic        r_wb_en, n_wb_en;
  logic [4:0]  r_wb_addr, n_wb_addr;
  logic [63:0] r_wb_data, n_wb_data;
  logic        r_set_pend, n_set_pend, r_clr_pend, n_clr_pend, r_word;
  logic        need_md, md_word;
  logic [63:0] md_a, md_b, md_res;
  logic        md_done;

  // Decode fields.
  logic [6:0]  op, f7;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [5:0]  f6;
  logic [63:0] a, b, y, immi, imms, immu, immb, immj, pc4, wres;
  logic        ok, alu_ok, lt_s, lt_u;

  assign ra1 = in_item.instruction[19:15];
  assign ra2 = (in_item.instruction[6:0] == OP_SYSTEM) ? REG_A0 : in_item.instruction[24:20];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q1      <= rf[ra1];
      q2      <= rf[ra2];
      cur_cmd <= in_item.command;
      ins     <= in_item.instruction;
      ldata   <= in_item.load_data;
    end
    if (cmd.commit && r_wb_en) begin
      rf[r_wb_addr] <= r_wb_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= 32'd0;
      v1       <= 1'b0;
      v2       <= 1'b0;
    end else begin
      if (cmd.capture) begin
        v1 <= rf_valid[ra1];
        v2 <= rf_valid[ra2];
      end
      if (cmd.commit && r_wb_en) begin
        rf_valid[r_wb_addr] <= 1'b1;
      end
    end
  end

  assign a = v1 ? q1 : 64'd0;
  assign b = v2 ? q2 : 64'd0;

  assign op   = ins[6:0];
  assign rd   = ins[11:7];
  assign f3   = ins[14:12];
  assign f7   = ins[31:25];
  assign f6   = ins[31:26];
  assign immi = {{52{ins[31]}}, ins[31:20]};
  assign imms = {{52{ins[31]}}, ins[31:25], ins[11:7]};
  assign immu = {{32{ins[31]}}, ins[31:12], 12'd0};
  assign immb = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign immj = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign pc4  = pc + 64'd4;
  assign y    = ((op == OP_IMM) || (op == OP_IMM32)) ? immi : b;
  assign lt_s = $signed(a) < $signed(y);
  assign lt_u = a < y;
  assign md_word = (op == OP_REG32);

  // Integer ALU for register and immediate forms.
  always_comb begin
    alu_ok = 1'b1;
    wres   = 64'd0;
    if ((op == OP_IMM) || (op == OP_REG)) begin
      case (f3)
        3'd0: wres = ((op == OP_REG) && ins[30]) ? (a - y) : (a + y);
        3'd1: wres = a << y[5:0];
        3'd2: wres = {63'd0, lt_s};
        3'd3: wres = {63'd0, lt_u};
        3'd4: wres = a ^ y;
        3'd5: wres = ins[30] ? 64'($signed(a) >>> y[5:0]) : (a >> y[5:0]);
        3'd6: wres = a | y;
        default: wres = a & y;
      endcase
      if (op == OP_IMM) begin
        if (f3 == 3'd1) alu_ok = (f6 == F6_BASE);
        if (f3 == 3'd5) alu_ok = (f6 == F6_BASE) || (f6 == F6_ALT);
      end else begin
        alu_ok = (f7 == F7_BASE) || ((f7 == F7_ALT) && ((f3 == 3'd0) || (f3 == 3'd5)));
      end
    end else begin
      case (f3)
        3'd0: wres = sext32(((op == OP_REG32) && ins[30]) ? (a[31:0] - y[31:0])
                                                        : (a[31:0] + y[31:0]));
        3'd1: wres = sext32(a[31:0] << y[4:0]);
        3'd5: wres = ins[30] ? sext32(32'($signed(a[31:0]) >>> y[4:0]))
                             : sext32(a[31:0] >> y[4:0]);
        default: wres = 64'd0;
      endcase
      if ((op == OP_REG32) || (f3 != 3'd0)) begin
        alu_ok = ((f7 == F7_BASE) && ((f3 == 3'd0) || (f3 == 3'd1) || (f3 == 3'd5)))
              || ((f7 == F7_ALT) && (((f3 == 3'd0) && (op == OP_REG32)) || (f3 == 3'd5)));
      end
    end
  end

  // Operands for the multiply and divide unit; word divide and remainder forms are extended first.
  always_comb begin
    md_a = a;
    md_b = b;
    if (md_word) begin
      if ((f3 == 3'd4) || (f3 == 3'd6)) begin
        md_a = sext32(a[31:0]);
        md_b = sext32(b[31:0]);
      end else if (f3 != 3'd0) begin
        md_a = {32'd0, a[31:0]};
        md_b = {32'd0, b[31:0]};
      end
    end
  end

  always_comb begin
    n_item = '0;
    n_item.status   = ST_OK;
    n_item.instr_pc = pc;
    n_item.next_pc  = pc4;
    n_wb_en    = 1'b0;
    n_wb_addr  = rd;
    n_wb_data  = 64'd0;
    n_set_pend = 1'b0;
    n_clr_pend = 1'b0;
    need_md    = 1'b0;
    ok         = 1'b1;
    if (cur_cmd == CMD_LOAD) begin
      n_item.next_pc = pc;
      if (!load_pending) begin
        n_item.status = ST_PROTO;
      end else begin
        n_item.instr_pc = pc - 64'd4;
        n_clr_pend = 1'b1;
        n_wb_en    = (load_dest != 5'd0);
        n_wb_addr  = load_dest;
        case (load_kind)
          3'd0: n_wb_data = {{56{ldata[7]}}, ldata[7:0]};
          3'd1: n_wb_data = {{48{ldata[15]}}, ldata[15:0]};
          3'd2: n_wb_data = sext32(ldata[31:0]);
          3'd3: n_wb_data = ldata;
          3'd4: n_wb_data = {56'd0, ldata[7:0]};
          3'd5: n_wb_data = {48'd0, ldata[15:0]};
          default: n_wb_data = {32'd0, ldata[31:0]};
        endcase
      end
    end else if (load_pending) begin
      n_item.status  = ST_PROTO;
      n_item.next_pc = pc;
    end else begin
      case (op)
        OP_LUI: begin
          n_wb_en = 1'b1; n_wb_data = immu;
        end
        OP_AUIPC: begin
          n_wb_en = 1'b1; n_wb_data = pc + immu;
        end
        OP_JAL: begin
          n_wb_en = 1'b1; n_wb_data = pc4; n_item.next_pc = pc + immj;
        end
        OP_JALR: begin
          ok = (f3 == 3'd0);
          n_wb_en = 1'b1; n_wb_data = pc4;
          n_item.next_pc = (a + immi) & ~64'd1;
        end
        OP_BRANCH: begin
          case (f3)
            3'd0: if (a == b) n_item.next_pc = pc + immb;
            3'd1: if (a != b) n_item.next_pc = pc + immb;
            3'd4: if (lt_s) n_item.next_pc = pc + immb;
            3'd5: if (!lt_s) n_item.next_pc = pc + immb;
            3'd6: if (lt_u) n_item.next_pc = pc + immb;
            3'd7: if (!lt_u) n_item.next_pc = pc + immb;
            default: ok = 1'b0;
          endcase
        end
        OP_LOAD: begin
          ok = (f3 != 3'd7);
          n_item.mem_read  = 1'b1;
          n_item.mem_addr  = a + immi;
          n_item.mem_bytes = 4'd1 << f3[1:0];
          n_set_pend = 1'b1;
        end
        OP_STORE: begin
          ok = !f3[2];
          n_item.mem_write  = 1'b1;
          n_item.mem_addr   = a + imms;
          n_item.mem_bytes  = 4'd1 << f3[1:0];
          n_item.store_data = b;
        end
        OP_IMM, OP_IMM32: begin
          ok = alu_ok; n_wb_en = 1'b1; n_wb_data = wres;
        end
        OP_REG, OP_REG32: begin
          if (f7 == F7_MULDIV) begin
            ok = !md_word || (f3 == 3'd0) || f3[2];
            need_md = ok;
            n_wb_en = 1'b1;
          end else begin
            ok = alu_ok; n_wb_en = 1'b1; n_wb_data = wres;
          end
        end
        OP_FENCE: begin
          ok = (f3 == 3'd0);
        end
        OP_SYSTEM: begin
          n_item.next_pc = pc;
          if (ins == INS_EBREAK) begin
            n_item.status    = ST_HALT;
            n_item.halt_code = b;
          end else if ((ins == INS_ECALL) || (ins == INS_MRET)) begin
            n_item.status = ST_SYSTEM;
          end else if ((f3 != 3'd0) && (f3 != 3'd4)) begin
            n_item.status = ST_SYSTEM;
          end else begin
            n_item.status = ST_INVALID;
          end
        end
        default: ok = 1'b0;
      endcase
      if (op == OP_SYSTEM || rd == 5'd0) n_wb_en = 1'b0;
      if (!ok) begin
        n_item.status     = ST_INVALID;
        n_item.next_pc    = pc;
        n_item.mem_read   = 1'b0;
        n_item.mem_write  = 1'b0;
        n_item.mem_addr   = 64'd0;
        n_item.mem_bytes  = 4'd0;
        n_item.store_data = 64'd0;
        n_wb_en    = 1'b0;
        n_set_pend = 1'b0;
        need_md    = 1'b0;
      end
    end
  end

  rvex_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.md_start),
    .fn     (f3),
    .a      (md_a),
    .b      (md_b),
    .done   (md_done),
    .result (md_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      r_item     <= n_item;
      r_wb_en    <= n_wb_en;
      r_wb_addr  <= n_wb_addr;
      r_wb_data  <= n_wb_data;
      r_set_pend <= n_set_pend;
      r_clr_pend <= n_clr_pend;
      r_word     <= md_word;
    end else if (cmd.md_take) begin
      r_wb_data <= r_word ? sext32(md_res[31:0]) : md_res;
    end
    if (cmd.commit) begin
      out_item <= r_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_pc <= RESET_PC_DEFAULT;
    end else if (cfg_write) begin
      reset_pc <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= reset_pc;
      load_pending <= 1'b0;
      load_dest    <= 5'd0;
      load_kind    <= 3'd0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.commit) begin
        pc <= r_item.next_pc;
        if (r_set_pend) begin
          load_pending <= 1'b1;
          load_dest    <= rd;
          load_kind    <= f3;
        end else if (r_clr_pend) begin
          load_pending <= 1'b0;
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.need_md  = need_md;
  assign stat.md_done  = md_done;
  assign stat.out_free = !out_valid || !out_stall;

endmodule
`default_nettype wire

>>> hw/rtl/rvex_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_ctrl
// Sequencing state machine: capture, execute, wait on multiply/divide, commit.
// ----------------------------------------------------------------------------
module rvex_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rvex_pkg::dp_stat_t stat,
  output rvex_pkg::ctl_cmd_t      cmd
);
  import rvex_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: state_next = stat.need_md ? S_WAIT : S_DONE;
      S_WAIT: if (stat.md_done) state_next = S_DONE;
      S_DONE: if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.exec     = 1'b1;
        cmd.md_start = stat.need_md;
      end
      S_WAIT: cmd.md_take = stat.md_done;
      S_DONE: cmd.commit  = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire
